// ----- rtl/core/scgs_pkg.sv -----
// Shared types and constants for the shortcode glyph substituter.
// Holds the shortcode table, default sizes and the queue item type.
// No dependencies.
`timescale 1ns / 1ps

package scgs_pkg;

  localparam int CODE_TABLE_SIZE  = 8;
  localparam int CODE_TABLE_WIDTH = 9;
  localparam int DEF_MAX_CODE_LEN = 9;
  localparam int DEF_NUM_CODES    = 8;
  localparam int QUEUE_DEPTH      = 2;

  localparam logic [7:0] COLON = 8'h3A;

  // Shortcode spellings, in priority order, padded with zero bytes.
  localparam logic [7:0] CODE_TEXT [CODE_TABLE_SIZE][CODE_TABLE_WIDTH] = '{
    '{":", "h", "e", "a", "r", "t", ":", 8'h00, 8'h00},
    '{":", "s", "m", "i", "l", "e", ":", 8'h00, 8'h00},
    '{":", "s", "m", "i", "l", "e", "b", ":", 8'h00},
    '{":", "s", "p", "a", "r", "k", "l", "e", ":"},
    '{":", "d", "i", "a", "m", "o", "n", "d", ":"},
    '{":", "n", "o", "t", "e", ":", 8'h00, 8'h00, 8'h00},
    '{":", "n", "o", "t", "e", "s", ":", 8'h00, 8'h00},
    '{":", "s", "t", "a", "r", ":", 8'h00, 8'h00, 8'h00}
  };

  localparam int CODE_LEN [CODE_TABLE_SIZE] = '{7, 7, 8, 9, 9, 6, 7, 6};

  localparam logic [7:0] CODE_GLYPH [CODE_TABLE_SIZE] = '{
    8'h03, 8'h01, 8'h02, 8'h0F, 8'h04, 8'h0D, 8'h0E, 8'h07
  };

  // One accepted character on its way from the front to the scanner.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       colon;
  } scgs_item_t;

endpackage

// ----- rtl/core/scgs_front.sv -----
// Input side of the substituter: takes transfers and tags colon bytes.
// Depends on scgs_pkg for the item type and the colon code.
`timescale 1ns / 1ps

module scgs_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_last,
  input  logic              q_full,
  output logic              push,
  output scgs_pkg::scgs_item_t push_item
);
  import scgs_pkg::*;

  assign in_ready = !q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    push_item.data  = in_byte;
    push_item.last  = in_last;
    push_item.colon = (in_byte == COLON);
  end

endmodule

// ----- rtl/core/scgs_queue.sv -----
// Small FIFO of classified items between the front and the scanner.
// Depends on scgs_pkg for the item type and queue depth.
`timescale 1ns / 1ps

module scgs_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  scgs_pkg::scgs_item_t push_item,
  output logic              full,
  input  logic              pop,
  output scgs_pkg::scgs_item_t pop_item,
  output logic              empty
);
  import scgs_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  scgs_item_t     entries [QUEUE_DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [CW-1:0]  count;

  assign full     = (count == CW'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- rtl/core/scgs_back.sv -----
// Scanner of the substituter: lookahead buffer, code matching and output register.
// Depends on scgs_pkg for the shortcode table and the item type.
`timescale 1ns / 1ps

module scgs_back #(
  parameter int MAX_CODE_LEN = scgs_pkg::DEF_MAX_CODE_LEN,
  parameter int NUM_CODES    = scgs_pkg::DEF_NUM_CODES
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  scgs_pkg::scgs_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_last
);
  import scgs_pkg::*;

  localparam int FW = $clog2(MAX_CODE_LEN + 1);
  localparam int IW = $clog2(MAX_CODE_LEN);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  logic                         state;
  logic [MAX_CODE_LEN-1:0][7:0] lbuf;
  logic [FW-1:0]                fill;
  logic                         cur_last;

  logic [CODE_TABLE_SIZE-1:0][CODE_TABLE_WIDTH-1:0] hit;
  logic [CODE_TABLE_SIZE-1:0]   cand;
  logic [CODE_TABLE_SIZE-1:0]   full;
  logic                         front_colon;

  logic                         dec_wait;
  logic [7:0]                   dec_byte;
  logic [FW-1:0]                dec_amt;
  logic [FW-1:0]                fill_next;

  logic                         out_free;
  logic                         fast;
  logic                         append;
  logic                         scan_emit;
  logic                         load;
  logic [7:0]                   ld_byte;
  logic                         ld_last;

  assign front_colon = (lbuf[0] == COLON);

  // Prefix compare of every usable code against the pending bytes.
  for (genvar i = 0; i < CODE_TABLE_SIZE; i++) begin : g_code
    if ((i < NUM_CODES) && (CODE_LEN[i] <= MAX_CODE_LEN)) begin : g_used
      for (genvar k = 0; k < CODE_TABLE_WIDTH; k++) begin : g_pos
        if (k < CODE_LEN[i]) begin : g_cmp
          assign hit[i][k] = (fill <= FW'(k)) || (lbuf[k] == CODE_TEXT[i][k]);
        end else begin : g_pad
          assign hit[i][k] = 1'b1;
        end
      end
      assign cand[i] = front_colon && (&hit[i]);
      assign full[i] = (fill >= FW'(CODE_LEN[i]));
    end else begin : g_unused
      assign hit[i]  = '1;
      assign cand[i] = 1'b0;
      assign full[i] = 1'b0;
    end
  end

  // First code in table order that either completes or must be waited on.
  always_comb begin
    logic found;
    found    = 1'b0;
    dec_wait = 1'b0;
    dec_byte = lbuf[0];
    dec_amt  = FW'(1);
    for (int i = 0; i < CODE_TABLE_SIZE; i++) begin
      if (!found && cand[i] && (full[i] || !cur_last)) begin
        found = 1'b1;
        if (full[i]) begin
          dec_byte = CODE_GLYPH[i];
          dec_amt  = FW'(CODE_LEN[i]);
        end else begin
          dec_wait = 1'b1;
        end
      end
    end
  end

  assign fill_next = fill - dec_amt;
  assign out_free  = !out_valid || out_ready;

  assign fast      = (state == ST_IDLE) && !q_empty && (fill == '0) && !q_item.colon
                     && out_free;
  assign append    = (state == ST_IDLE) && !q_empty && !fast;
  assign scan_emit = (state == ST_SCAN) && !dec_wait && out_free;
  assign q_pop     = fast || append;
  assign load      = fast || scan_emit;

  always_comb begin
    if (fast) begin
      ld_byte = q_item.data;
      ld_last = q_item.last;
    end else begin
      ld_byte = dec_byte;
      ld_last = cur_last && (fill_next == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (append) begin
      lbuf[fill[IW-1:0]] <= q_item.data;
    end else if (scan_emit) begin
      lbuf <= lbuf >> {dec_amt, 3'b000};
    end
    if (append) begin
      cur_last <= q_item.last;
    end
    if (load) begin
      out_byte <= ld_byte;
      out_last <= ld_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (append) begin
            fill  <= fill + 1'b1;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (dec_wait) begin
            state <= ST_IDLE;
          end else if (scan_emit) begin
            fill <= fill_next;
            if (fill_next == '0) begin
              state <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FW'(MAX_CODE_LEN))
    else $error("lookahead fill exceeded its capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (fill != '0))
    else $error("scan running on an empty buffer");

  a_no_wait_at_end: assert property (@(posedge clk) disable iff (rst)
    !((state == ST_SCAN) && cur_last && dec_wait))
    else $error("scanner waits on a string that has ended");

  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    (load && ld_last) |=> (fill == '0))
    else $error("final byte sent with bytes still pending");

endmodule

// ----- rtl/core/shortcode_glyph_substituter.sv -----
// Top level of the shortcode glyph substituter.
// Ties together scgs_front, scgs_queue and scgs_back; uses scgs_pkg.
`timescale 1ns / 1ps
//
//  channel | handshake             | payload            | direction
//  --------+-----------------------+--------------------+----------
//  input   | in_valid / in_ready   | in_byte, in_last   | into block
//  output  | out_valid / out_ready | out_byte, out_last | out of block
//
// A transfer on the input lands in a two-entry queue in the following cycle.
// A plain byte with nothing pending and a free output goes straight to the
//   output register; otherwise the scanner appends the byte to the
//   lookahead, then emits each decided byte or glyph or stops to wait on an
//   undecided code, one compare-and-shift step per cycle while the output
//   is free.
// Reset (rst, synchronous) empties the queue, the lookahead and the output.
// A stall on the output holds the scanner; the queue keeps taking input
//   until it fills, then in_ready drops.

module shortcode_glyph_substituter #(
  parameter int MAX_CODE_LEN = scgs_pkg::DEF_MAX_CODE_LEN,
  parameter int NUM_CODES    = scgs_pkg::DEF_NUM_CODES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import scgs_pkg::*;

  logic       push;
  scgs_item_t push_item;
  logic       q_full;
  logic       q_empty;
  logic       q_pop;
  scgs_item_t q_item;

  // Accept and tag input bytes.
  scgs_front u_front (
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  // Decouple input acceptance from scanning.
  scgs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .pop_item  (q_item),
    .empty     (q_empty)
  );

  // Match shortcodes, emit glyphs or passthrough bytes.
  scgs_back #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_CODES    (NUM_CODES)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ----- dv/scgs_glyph_checker.sv -----
// Scoreboard for the shortcode glyph substituter: watches both channels.
// Predicts the emitted byte stream from input transfers and compares output transfers.
// Depends on scgs_pkg for the shortcode table.
`timescale 1ns / 1ps

module scgs_glyph_checker #(
  parameter int MAX_CODE_LEN = scgs_pkg::DEF_MAX_CODE_LEN,
  parameter int NUM_CODES    = scgs_pkg::DEF_NUM_CODES
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       out_valid,
  input  logic       out_ready,
  input  logic [7:0] out_byte,
  input  logic       out_last,
  output int         errors,
  output int         pending,
  output int         bytes_out
);
  import scgs_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } glyph_out_t;

  glyph_out_t expected_out [$];
  glyph_out_t head;
  logic [7:0] held_chars [MAX_CODE_LEN];
  int         held_fill = 0;

  initial begin
    errors    = 0;
    pending   = 0;
    bytes_out = 0;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] ERROR: %s", $realtime, msg);
    errors++;
  endtask

  function automatic void drop_held(input int n);
    for (int k = 0; k + n < held_fill; k++) held_chars[k] = held_chars[k + n];
    held_fill = (n >= held_fill) ? 0 : held_fill - n;
  endfunction

  // Append one character to the lookahead and emit whatever is decided.
  task automatic predict_glyphs(input logic [7:0] ch, input logic fin);
    logic [7:0] made [$];
    bit         hold;
    bit         hit;
    bit         same;
    int         cl;
    int         lim;
    if (held_fill >= MAX_CODE_LEN) begin
      made.push_back(held_chars[0]);
      drop_held(1);
    end
    held_chars[held_fill] = ch;
    held_fill++;
    while (held_fill > 0) begin
      hold = 0;
      hit  = 0;
      if (held_chars[0] == COLON) begin
        for (int i = 0; i < NUM_CODES && i < CODE_TABLE_SIZE; i++) begin
          cl = CODE_LEN[i];
          if (cl > MAX_CODE_LEN) continue;
          lim  = (held_fill < cl) ? held_fill : cl;
          same = 1;
          for (int k = 0; k < lim; k++) begin
            if (held_chars[k] != CODE_TEXT[i][k]) begin
              same = 0;
              break;
            end
          end
          if (!same) continue;
          if (held_fill >= cl) begin
            made.push_back(CODE_GLYPH[i]);
            drop_held(cl);
            hit = 1;
            break;
          end
          // an earlier code could still complete: hold everything
          if (!fin) begin
            hold = 1;
            break;
          end
        end
      end
      if (hold) break;
      if (!hit) begin
        made.push_back(held_chars[0]);
        drop_held(1);
      end
    end
    foreach (made[j])
      expected_out.push_back('{data: made[j], last: fin && (j == made.size() - 1)});
  endtask

  always @(posedge clk) begin
    if (rst) begin
      held_fill = 0;
      expected_out.delete();
    end else begin
      if (in_valid && in_ready) predict_glyphs(in_byte, in_last);
      if (out_valid && out_ready) begin
        bytes_out++;
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("unexpected output byte %02h last %0b", out_byte, out_last));
        end else begin
          head = expected_out.pop_front();
          if (out_byte !== head.data)
            report_mismatch($sformatf("out_byte %02h, expected %02h", out_byte, head.data));
          if (out_last !== head.last)
            report_mismatch($sformatf("out_last %0b, expected %0b (byte %02h)",
                                      out_last, head.last, head.data));
        end
      end
    end
    pending = expected_out.size();
  end

endmodule

// ----- dv/shortcode_glyph_substituter_tb.sv -----
// Testbench top for the shortcode glyph substituter: clock, reset, stimulus, verdict.
// Drives directed and random text strings under varying pacing; scgs_glyph_checker scores.
// Depends on scgs_pkg, scgs_glyph_checker and the RTL top.
`timescale 1ns / 1ps

module shortcode_glyph_substituter_tb;
  import scgs_pkg::*;

  localparam int RANDOM_BYTES = 320;
  localparam int SETTLE_CYCLES = 40;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  logic [7:0] in_byte   = 8'h00;
  logic       in_last   = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  int errors;
  int pending;
  int bytes_out;

  // Pacing knobs, in percent per cycle.
  int idle_pct  = 0;
  int stall_pct = 0;

  int sent_bytes   = 0;
  int sent_strings = 0;

  logic [7:0] text_q [$];

  always #5 clk = ~clk;

  shortcode_glyph_substituter dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  scgs_glyph_checker checker_i (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_byte (out_byte),
    .out_last (out_last),
    .errors   (errors),
    .pending  (pending),
    .bytes_out(bytes_out)
  );

  // Receiver side: stall at random, one decision per cycle.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= stall_pct);
  end

  // Present one byte and hold it until the transfer happens. Idle cycles
  // go in front, so valid only drops when a gap is actually taken.
  task automatic send_byte(input logic [7:0] b, input logic fin);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    in_last  <= fin;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
  endtask

  // Send text_q as one string, flagging its final byte.
  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    sent_strings++;
    text_q.delete();
  endtask

  task automatic append_chars(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Build one random string from segments: well-formed codes, most often,
  // and truncated codes, corrupted codes, stray colons and noise bytes.
  task automatic build_random_text();
    int segs;
    int kind;
    int idx;
    int len;
    int pos;
    segs = $urandom_range(1, 6);
    for (int s = 0; s < segs; s++) begin
      kind = $urandom_range(99);
      idx  = $urandom_range(CODE_TABLE_SIZE - 1);
      len  = CODE_LEN[idx];
      if (kind < 45) begin
        for (int k = 0; k < len; k++) text_q.push_back(CODE_TEXT[idx][k]);
      end else if (kind < 60) begin
        pos = $urandom_range(1, len - 1);
        for (int k = 0; k < pos; k++) text_q.push_back(CODE_TEXT[idx][k]);
      end else if (kind < 70) begin
        pos = $urandom_range(1, len - 1);
        for (int k = 0; k < len; k++)
          text_q.push_back(k == pos ? 8'($urandom_range(1, 255)) : CODE_TEXT[idx][k]);
      end else if (kind < 78) begin
        text_q.push_back(COLON);
      end else begin
        repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom_range(1, 255)));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed strings, no pacing gaps.
    // Undecided code: ":smile" must wait for the longer ":smileb:".
    append_chars(":smileb:");
    send_text();
    // Colon that fails, followed straight by a real code.
    append_chars("::star:");
    send_text();
    // Incomplete code at end of string flushes as plain bytes.
    append_chars(":note");
    send_text();
    // Zero byte passes through; all-ones byte closes the string.
    text_q.push_back(8'h00);
    text_q.push_back(8'hFF);
    send_text();
    // One-byte string.
    append_chars("x");
    send_text();

    // Random strings across four pacing phases.
    while (sent_bytes < RANDOM_BYTES + 23) begin
      case ((sent_bytes - 23) * 4 / RANDOM_BYTES)
        0: begin
          idle_pct  = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct  = 85;
          stall_pct = 0;
        end
        2: begin
          idle_pct  = 0;
          stall_pct = 85;
        end
        default: begin
          idle_pct  = 14;
          stall_pct = 14;
        end
      endcase
      build_random_text();
      send_text();
    end

    // Drain: release the input, stop stalling, wait for the last expectation.
    in_valid  <= 1'b0;
    stall_pct = 0;
    idle_pct  = 0;
    do @(negedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d strings under four pacing phases; received %0d bytes.",
             sent_bytes, sent_strings, bytes_out);
    $display("Covered full, truncated and corrupted shortcodes, stray colons and noise bytes.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #5ms;
    $display("Timeout with %0d results still expected", pending);
    $display("Verification failed");
    $finish;
  end

endmodule
